// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the clock and baud divisor block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/cbd_pkg.sv =====
// Types, constants and tables of the clock tree and baud divisor calculator.
package cbd_pkg;

	localparam int DivStages = 32;
	localparam int DvsW = 26;

	localparam logic [1:0] SW_HSE = 2'd1;
	localparam logic [1:0] SW_PLL = 2'd2;

	localparam logic [25:0] HSE_RESET = 26'd25000000;
	localparam logic [25:0] HSI_RESET = 26'd16000000;
	localparam logic [23:0] BAUD_RESET = 24'd9600;

	localparam logic [3:0] SHIFT_TBL [16] = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4,
		4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9};

	// Reciprocal of 100 for a 32-bit dividend, used with a shift of 37.
	localparam logic [31:0] RECIP100 = 32'h51EB851F;
	// Reciprocal of 100 for an 11-bit dividend, used with a shift of 19.
	localparam logic [12:0] RECIP100_SMALL = 13'd5243;
	localparam logic [10:0] ROUND_MARGIN = 11'd50;

	typedef enum logic [1:0] {
		REG_HSE  = 2'd0,
		REG_HSI  = 2'd1,
		REG_BAUD = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] clock_switch;
		logic       pll_from_hse;
		logic [5:0] pll_m;
		logic [8:0] pll_n;
		logic [1:0] pll_p_code;
		logic [3:0] ahb_presc_code;
		logic [2:0] apb1_presc_code;
		logic [2:0] apb2_presc_code;
		logic       oversample8;
	} item_t;

	typedef struct packed {
		logic [31:0] sysclk_hz;
		logic [31:0] hclk_hz;
		logic [31:0] pclk1_hz;
		logic [31:0] pclk2_hz;
		logic [15:0] baud_divisor;
		logic        config_error;
	} result_t;

	typedef struct packed {
		logic [25:0] hse_hz;
		logic [25:0] hsi_hz;
		logic [23:0] baud_rate;
	} cfg_t;

	typedef struct packed {
		item_t       item;
		logic        err;
		logic [31:0] sysclk;
		logic [31:0] hclk;
		logic [31:0] pclk1;
		logic [31:0] pclk2;
	} pipe_t;

endpackage

// ===== hw/rtl/cbd_regs.sv =====
// Configuration registers behind the APB-style port.
module cbd_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output cbd_pkg::cfg_t       cfg
);
	import cbd_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hse_hz <= HSE_RESET;
			cfg_q.hsi_hz <= HSI_RESET;
			cfg_q.baud_rate <= BAUD_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_HSE: begin
					cfg_q.hse_hz <= pwdata[25:0];
				end
				REG_HSI: begin
					cfg_q.hsi_hz <= pwdata[25:0];
				end
				REG_BAUD: begin
					cfg_q.baud_rate <= pwdata[23:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_HSE:  prdata = {6'd0, cfg_q.hse_hz};
			REG_HSI:  prdata = {6'd0, cfg_q.hsi_hz};
			REG_BAUD: prdata = {8'd0, cfg_q.baud_rate};
			default:  prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/cbd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module cbd_div (
	input  logic        clk,
	input  logic        adv,
	input  logic [31:0] dividend,
	input  logic [25:0] divisor,
	output logic [31:0] quotient
);
	import cbd_pkg::*;

	logic [31:0]     quo_s [DivStages];
	logic [DvsW-1:0] rem_s [DivStages];
	logic [DvsW-1:0] dvs_s [DivStages];

	for (genvar k = 0; k < DivStages; k++) begin : g_stage
		logic [31:0]     q_in;
		logic [DvsW-1:0] r_in;
		logic [DvsW-1:0] d_in;
		logic [DvsW:0]   trial;
		logic [DvsW:0]   diff;
		logic [31:0]     q_nx;
		logic [DvsW-1:0] r_nx;

		if (k == 0) begin : g_first
			assign q_in = dividend;
			assign r_in = '0;
			assign d_in = divisor;
		end else begin : g_next
			assign q_in = quo_s[k-1];
			assign r_in = rem_s[k-1];
			assign d_in = dvs_s[k-1];
		end

		always_comb begin
			trial = {r_in, q_in[31]};
			diff = trial - {1'b0, d_in};
			if (trial >= {1'b0, d_in}) begin
				r_nx = diff[DvsW-1:0];
				q_nx = {q_in[30:0], 1'b1};
			end else begin
				r_nx = trial[DvsW-1:0];
				q_nx = {q_in[30:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				quo_s[k] <= q_nx;
				rem_s[k] <= r_nx;
				dvs_s[k] <= d_in;
			end
		end
	end

	assign quotient = quo_s[DivStages-1];

endmodule

// ===== hw/rtl/cbd_line.sv =====
// Word and valid delay line that runs alongside a divider.
module cbd_line (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           d_valid,
	input  cbd_pkg::pipe_t d,
	output logic           q_valid,
	output cbd_pkg::pipe_t q
);
	import cbd_pkg::*;

	logic [DivStages-1:0] v_s;
	pipe_t                p_s [DivStages];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[DivStages-2:0], d_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s[0] <= d;
			for (int k = 1; k < DivStages; k++) begin
				p_s[k] <= p_s[k-1];
			end
		end
	end

	assign q_valid = v_s[DivStages-1];
	assign q = p_s[DivStages-1];

endmodule

// ===== hw/rtl/clock_tree_and_baud_divisor_calc.sv =====
// Clock tree and baud divisor calculator: a new clock configuration word can be
// accepted every cycle unless both output buffer entries are held. Each word
// passes through three 32-stage pipelined dividers in series (PLL input divider,
// PLL output divider, baud divider) and eight registered stages for the PLL
// source pick, PLL product, prescaler shifts, baud product, divide by 100 and
// fraction rounding. A two-word output buffer lets the pipeline keep taking
// words while a finished result waits; the input stalls only when both buffer
// entries are held.
module clock_tree_and_baud_divisor_calc (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  cbd_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output cbd_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import cbd_pkg::*;

	`include "assert_macros.svh"

	cfg_t        cfg;
	logic        adv;

	logic        v_s1;
	pipe_t       p_s1;
	logic [25:0] src_s1;
	pipe_t       nx_s1;

	logic [31:0] qa;
	logic        va;
	pipe_t       pa;
	logic [40:0] pll_prod;
	pipe_t       nx_s2;

	logic        v_s2;
	pipe_t       p_s2;
	logic [30:0] half_s2;
	logic [2:0]  pdiv_s2;

	logic [31:0] qb;
	logic        vb;
	pipe_t       pb;
	logic [31:0] sys_nx;
	pipe_t       nx_s3;
	pipe_t       nx_s4;
	pipe_t       nx_s5;

	logic        v_s3;
	pipe_t       p_s3;
	logic        v_s4;
	pipe_t       p_s4;

	logic [36:0] baud_prod;
	logic        v_s5;
	pipe_t       p_s5;
	logic [31:0] wide_s5;
	logic [25:0] dvs_s5;

	logic [31:0] qc;
	logic        vc;
	pipe_t       pc;

	logic        v_s6;
	pipe_t       p_s6;
	logic [63:0] prod_s6;
	logic [6:0]  dlow_s6;

	logic        v_s7;
	pipe_t       p_s7;
	logic [11:0] mant_s7;
	logic [6:0]  frac_s7;

	logic [10:0] round_x;
	logic [23:0] round_prod;
	logic [3:0]  fpart;
	logic        v_s8;
	result_t     res_nx;
	result_t     res_s8;

	result_t     ent0_q;
	result_t     ent1_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;
	logic        err_clear;

	cbd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The whole pipeline moves together unless both output entries are held.
	assign adv = (cnt_q != 2'd2);
	assign item_ready = adv;

	// Stage 1: pick the PLL source and flag a zero input divider.
	always_comb begin
		nx_s1 = '0;
		nx_s1.item = item;
		nx_s1.err = (item.clock_switch == SW_PLL) && (item.pll_m == 6'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= nx_s1;
			src_s1 <= item.pll_from_hse ? cfg.hse_hz : cfg.hsi_hz;
		end
	end

	cbd_div u_div_a (
		.clk      (clk),
		.adv      (adv),
		.dividend ({6'd0, src_s1}),
		.divisor  ({20'd0, p_s1.item.pll_m}),
		.quotient (qa)
	);

	cbd_line u_line_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.d_valid (v_s1),
		.d       (p_s1),
		.q_valid (va),
		.q       (pa)
	);

	// Stage 2: PLL multiply and overflow check; the divide by (p+1)*2 is a
	// halving followed by a divide by p+1.
	assign pll_prod = {9'd0, qa} * {32'd0, pa.item.pll_n};

	always_comb begin
		nx_s2 = pa;
		nx_s2.err = pa.err || ((pa.item.clock_switch == SW_PLL) &&
			(pll_prod[40:32] != 9'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= va;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2 <= nx_s2;
			half_s2 <= pll_prod[31:1];
			pdiv_s2 <= {1'b0, pa.item.pll_p_code} + 3'd1;
		end
	end

	cbd_div u_div_b (
		.clk      (clk),
		.adv      (adv),
		.dividend ({1'b0, half_s2}),
		.divisor  ({23'd0, pdiv_s2}),
		.quotient (qb)
	);

	cbd_line u_line_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.d_valid (v_s2),
		.d       (p_s2),
		.q_valid (vb),
		.q       (pb)
	);

	// Stage 3: system clock select and AHB prescaler.
	always_comb begin
		unique case (pb.item.clock_switch)
			SW_HSE:  sys_nx = {6'd0, cfg.hse_hz};
			SW_PLL:  sys_nx = qb;
			default: sys_nx = {6'd0, cfg.hsi_hz};
		endcase
	end

	always_comb begin
		nx_s3 = pb;
		nx_s3.sysclk = sys_nx;
		nx_s3.hclk = sys_nx >> SHIFT_TBL[pb.item.ahb_presc_code];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s3 <= vb;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3 <= nx_s3;
		end
	end

	// Stage 4: APB prescalers.
	always_comb begin
		nx_s4 = p_s3;
		nx_s4.pclk1 = p_s3.hclk >> SHIFT_TBL[{1'b0, p_s3.item.apb1_presc_code}];
		nx_s4.pclk2 = p_s3.hclk >> SHIFT_TBL[{1'b0, p_s3.item.apb2_presc_code}];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4 <= nx_s4;
		end
	end

	// Stage 5: scaled APB2 clock and the baud divisor.
	assign baud_prod = {5'd0, p_s4.pclk2} * 37'd25;

	always_comb begin
		nx_s5 = p_s4;
		nx_s5.err = p_s4.err || (cfg.baud_rate == 24'd0) ||
			(baud_prod[36:32] != 5'd0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s5 <= nx_s5;
			wide_s5 <= baud_prod[31:0];
			dvs_s5 <= p_s4.item.oversample8 ? {1'b0, cfg.baud_rate, 1'b0} :
				{cfg.baud_rate, 2'b00};
		end
	end

	cbd_div u_div_c (
		.clk      (clk),
		.adv      (adv),
		.dividend (wide_s5),
		.divisor  (dvs_s5),
		.quotient (qc)
	);

	cbd_line u_line_c (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.d_valid (v_s5),
		.d       (p_s5),
		.q_valid (vc),
		.q       (pc)
	);

	// Stages 6 and 7: divide by 100 through the reciprocal, then the remainder.
	// Only the low seven bits matter for a remainder below 100.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s6 <= vc;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s6 <= pc;
			prod_s6 <= {32'd0, qc} * {32'd0, RECIP100};
			dlow_s6 <= qc[6:0];
			p_s7 <= p_s6;
			mant_s7 <= prod_s6[48:37];
			frac_s7 <= dlow_s6 - 7'(prod_s6[43:37] * 7'd100);
		end
	end

	// Stage 8: rounded fraction; a carry out of the fraction is dropped.
	always_comb begin
		round_x = p_s7.item.oversample8 ? ({1'b0, frac_s7, 3'd0} + ROUND_MARGIN) :
			({frac_s7, 4'd0} + ROUND_MARGIN);
		round_prod = {13'd0, round_x} * {11'd0, RECIP100_SMALL};
		fpart = p_s7.item.oversample8 ? {1'b0, round_prod[21:19]} : round_prod[22:19];
	end

	always_comb begin
		res_nx = '0;
		res_nx.config_error = 1'b1;
		if (!p_s7.err) begin
			res_nx.sysclk_hz = p_s7.sysclk;
			res_nx.hclk_hz = p_s7.hclk;
			res_nx.pclk1_hz = p_s7.pclk1;
			res_nx.pclk2_hz = p_s7.pclk2;
			res_nx.baud_divisor = {mant_s7, fpart};
			res_nx.config_error = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s8 <= res_nx;
		end
	end

	// Two-word output buffer.
	assign push = adv && v_s8;
	assign pop = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					ent0_q <= res_s8;
				end else begin
					ent1_q <= res_s8;
				end
			end
			2'b01: begin
				ent0_q <= ent1_q;
			end
			2'b11: begin
				ent0_q <= res_s8;
			end
			default: begin
			end
		endcase
	end

	assign result_valid = (cnt_q != 2'd0);
	assign result = ent0_q;

	assign err_clear = (result.sysclk_hz == 32'd0) && (result.pclk2_hz == 32'd0) &&
		(result.baud_divisor == 16'd0);

	`ASSERT_ALWAYS(a_cnt_range, cnt_q != 2'd3, "output buffer count out of range")
	`ASSERT_ALWAYS(a_err_zero, !(result_valid && result.config_error) || err_clear, "error word carries nonzero fields")
	`ASSERT_NEXT(a_full_hold, (cnt_q == 2'd2) && !result_ready, cnt_q == 2'd2, "full buffer changed without a read")
	`ASSERT_NEXT(a_push_stall, (cnt_q == 2'd2) && !result_ready, $stable(v_s8) && $stable(v_s1), "pipeline moved while stalled")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the clock tree and baud divisor calculator.
`timescale 1ns / 1ps

module tb;
	import cbd_pkg::*;

	localparam int RandWords = 400;
	localparam int LatencyCycles = 140;
	localparam longint CycleLimit = 400000;
	localparam int ItemBits = $bits(item_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	clock_tree_and_baud_divisor_calc i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// Shadow copy of the block's registers.
	logic [25:0] hse_shadow;
	logic [25:0] hsi_shadow;
	logic [23:0] baud_shadow;

	result_t pending_results[$];
	int mismatches = 0;
	int words_sent = 0;
	int words_checked = 0;
	int error_words = 0;
	longint cycles = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	typedef struct {
		item_t   word;
		bit      typed;
		result_t want;
	} dir_row_t;

	function automatic logic [3:0] presc_shift(input logic [3:0] code);
		logic [3:0] lut [16];
		lut = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4,
			4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9};
		return lut[code];
	endfunction

	function automatic result_t clock_tree_calc(input item_t w);
		result_t r;
		logic [31:0] src, sysclk, hclk, d, mant, frac, fpart;
		logic [63:0] wide;
		r = '0;
		r.config_error = 1'b1;
		if (w.clock_switch == SW_HSE) begin
			sysclk = 32'(hse_shadow);
		end else if (w.clock_switch == SW_PLL) begin
			src = w.pll_from_hse ? 32'(hse_shadow) : 32'(hsi_shadow);
			if (w.pll_m == 0) return r;
			wide = 64'(src / 32'(w.pll_m)) * 64'(w.pll_n);
			if (wide > 64'hFFFF_FFFF) return r;
			sysclk = wide[31:0] / ((32'(w.pll_p_code) + 1) * 2);
		end else begin
			sysclk = 32'(hsi_shadow);
		end
		hclk = sysclk >> presc_shift(w.ahb_presc_code);
		r.sysclk_hz = sysclk;
		r.hclk_hz = hclk;
		r.pclk1_hz = hclk >> presc_shift({1'b0, w.apb1_presc_code});
		r.pclk2_hz = hclk >> presc_shift({1'b0, w.apb2_presc_code});
		if (baud_shadow == 0 || 64'(r.pclk2_hz) * 25 > 64'hFFFF_FFFF) begin
			return '{default: '0, config_error: 1'b1};
		end
		d = (r.pclk2_hz * 25) / ((w.oversample8 ? 32'd2 : 32'd4) * 32'(baud_shadow));
		mant = d / 100;
		frac = d - 100 * mant;
		if (w.oversample8) fpart = ((frac * 8 + 50) / 100) & 32'h7;
		else fpart = ((frac * 16 + 50) / 100) & 32'hF;
		r.baud_divisor = 16'((mant << 4) | fpart);
		r.config_error = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH %s: got %0d want %0d (word %0d)", what, got, want, words_checked);
		mismatches++;
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 4'(idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HSE: hse_shadow = value[25:0];
			REG_HSI: hsi_shadow = value[25:0];
			default: baud_shadow = value[23:0];
		endcase
	endtask

	// Starts and ends at a falling edge; valid drops only when a gap follows.
	task automatic send_word(input item_t w, input bit typed, input result_t want);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pending_results.push_back(typed ? want : clock_tree_calc(w));
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (LatencyCycles) @(negedge clk);
	endtask

	function automatic item_t rand_word(input bit sane);
		item_t w;
		w = ItemBits'($urandom);
		if (sane) begin
			w.pll_m = 6'($urandom_range(2, 63));
			w.pll_n = 9'($urandom_range(50, 432));
		end
		return w;
	endfunction

	task automatic random_phase(input int count);
		for (int k = 0; k < count; k++) begin
			send_word(rand_word($urandom_range(0, 4) != 0), 1'b0, '0);
		end
	endtask

	initial begin
		dir_row_t rows[$];
		item_t w;
		result_t zero_err;
		zero_err = '{default: '0, config_error: 1'b1};
		hse_shadow = HSE_RESET;
		hsi_shadow = HSI_RESET;
		baud_shadow = BAUD_RESET;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// HSI after reset with no division: 16 MHz everywhere.
		w = '0;
		rows.push_back('{w, 1'b1, '{32'd16000000, 32'd16000000, 32'd16000000,
			32'd16000000, 16'h0683, 1'b0}});
		w.clock_switch = 2'd3;
		rows.push_back('{w, 1'b0, '0});
		w.clock_switch = SW_HSE;
		rows.push_back('{w, 1'b0, '0});
		// PLL with a zero input divider.
		w = '0; w.clock_switch = SW_PLL; w.pll_n = 9'd336;
		rows.push_back('{w, 1'b1, zero_err});
		w.pll_m = 6'd1; w.pll_n = 9'd511; w.pll_from_hse = 1'b1;
		rows.push_back('{w, 1'b0, '0});
		w.pll_m = 6'd25; w.pll_n = 9'd336; w.pll_p_code = 2'd1;
		w.ahb_presc_code = 4'd0; w.apb1_presc_code = 3'd5; w.apb2_presc_code = 3'd4;
		rows.push_back('{w, 1'b0, '0});
		w.oversample8 = 1'b1;
		rows.push_back('{w, 1'b0, '0});
		w.pll_n = 9'd0;
		rows.push_back('{w, 1'b0, '0});
		w = '1; w.clock_switch = SW_PLL;
		rows.push_back('{w, 1'b0, '0});
		w.pll_p_code = 2'd0; w.ahb_presc_code = 4'd8; w.apb1_presc_code = 3'd0;
		w.apb2_presc_code = 3'd0; w.oversample8 = 1'b0;
		rows.push_back('{w, 1'b0, '0});
		for (int k = 0; k < 8; k++) begin
			w = '0; w.ahb_presc_code = 4'(k * 2 + 1);
			w.apb1_presc_code = 3'(k); w.apb2_presc_code = 3'(7 - k);
			w.oversample8 = k[0];
			rows.push_back('{w, 1'b0, '0});
		end
		foreach (rows[k]) send_word(rows[k].word, rows[k].typed, rows[k].want);
		drain();

		// Baud rate zero, then PLL overflow with a fast external source.
		reg_write(REG_BAUD, 32'd0);
		w = '0;
		send_word(w, 1'b1, zero_err);
		drain();
		reg_write(REG_BAUD, 32'd12000000);
		reg_write(REG_HSE, 32'd50000000);
		reg_write(REG_HSI, 32'd50000000);
		w = '0; w.clock_switch = SW_PLL; w.pll_m = 6'd1; w.pll_n = 9'd511;
		w.pll_from_hse = 1'b1;
		send_word(w, 1'b1, zero_err);
		w = '0; w.clock_switch = SW_HSE;
		send_word(w, 1'b0, '0);
		random_phase(40);
		drain();

		reg_write(REG_HSE, 32'd1);
		reg_write(REG_HSI, 32'd1);
		reg_write(REG_BAUD, 32'd1);
		random_phase(40);
		drain();

		// Receiver holds off while words keep coming, so the input stalls.
		fork
			random_phase(150);
			begin
				hold_off = 1'b1;
				repeat (800) @(negedge clk);
				hold_off = 1'b0;
			end
		join
		drain();

		for (int p = 0; p < 4; p++) begin
			reg_write(REG_HSE, $urandom_range(1, 50000000));
			reg_write(REG_HSI, $urandom_range(1, 50000000));
			reg_write(REG_BAUD, $urandom_range(0, 3) == 0 ? $urandom_range(1, 12000000)
				: $urandom_range(300, 921600));
			random_phase(RandWords / 10);
			drain();
		end
		stim_done = 1'b1;
	end

	// Result side: random stalls, checking every accepted word in order.
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
			if (stall != 0 || hold_off) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
				while (hold_off) @(negedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", result.sysclk_hz, 32'd0);
			end else begin
				result_t want;
				want = pending_results.pop_front();
				if (result.sysclk_hz !== want.sysclk_hz)
					report_mismatch("sysclk_hz", result.sysclk_hz, want.sysclk_hz);
				if (result.hclk_hz !== want.hclk_hz)
					report_mismatch("hclk_hz", result.hclk_hz, want.hclk_hz);
				if (result.pclk1_hz !== want.pclk1_hz)
					report_mismatch("pclk1_hz", result.pclk1_hz, want.pclk1_hz);
				if (result.pclk2_hz !== want.pclk2_hz)
					report_mismatch("pclk2_hz", result.pclk2_hz, want.pclk2_hz);
				if (result.baud_divisor !== want.baud_divisor)
					report_mismatch("baud_divisor", 32'(result.baud_divisor),
						32'(want.baud_divisor));
				if (result.config_error !== want.config_error)
					report_mismatch("config_error", 32'(result.config_error),
						32'(want.config_error));
				if (want.config_error) error_words++;
				words_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (stim_done) begin
			if (pending_results.size() != 0) begin
				report_mismatch("result words never arrived",
					32'(pending_results.size()), 32'd0);
			end
			$display("Sent %0d configuration words and checked %0d results, %0d of them errors,",
				words_sent, words_checked, error_words);
			$display("across reset, extreme and random register settings with a long output stall.");
			if (mismatches == 0) begin
				$display("Verification passed");
			end else begin
				$display("Verification failed");
			end
			$finish;
		end else if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

endmodule
